// File: rtl/core/cpss_pkg.sv
package cpss_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COORD_W    = 7;
  localparam int RADIUS_W   = 3;
  localparam int MARGIN_W   = 5;
  localparam int SHIFT_W    = 17;
  localparam int DIST_W     = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  // shifted test sum and candidate difference, signed
  localparam int TEST_W     = 21;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_LM      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_CB      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_CR      = 3'd4;

  typedef struct packed {
    op_e                 operation;
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row;
    logic [SAMPLE_W-1:0] lm_value;
    logic [SAMPLE_W-1:0] cb_value;
    logic [SAMPLE_W-1:0] cr_value;
  } req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] best_lm;
    logic [SAMPLE_W-1:0] best_cb;
    logic [SAMPLE_W-1:0] best_cr;
    logic [DIST_W-1:0]   min_distance;
    logic                out_of_range;
  } rsp_t;

  typedef struct packed {
    logic [RADIUS_W-1:0]       radius;
    logic [MARGIN_W-1:0]       margin;
    logic signed [SHIFT_W-1:0] shift_lm;
    logic signed [SHIFT_W-1:0] shift_cb;
    logic signed [SHIFT_W-1:0] shift_cr;
  } cfg_t;

  // sequencer to match tracker
  typedef struct packed {
    logic start;
    logic oor;
    logic rd_vld;
    logic rd_last;
  } scan_ctl_t;

endpackage

// File: rtl/core/cpss_stream_if.sv
interface cpss_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/cpss_ram.sv
module cpss_ram #(
  parameter int Width = 48,
  parameter int Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/cpss_cfg.sv
module cpss_cfg #(
  parameter int MAX_RADIUS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic [cpss_pkg::CFG_IDX_W-1:0]      idx_i,
  input  logic [cpss_pkg::CFG_DATA_W-1:0]     data_i,
  output cpss_pkg::cfg_t                      cfg_o,
  output logic [$clog2(MAX_RADIUS+1)-1:0]     radius_o
);
  import cpss_pkg::*;

  localparam int RadW = $clog2(MAX_RADIUS + 1);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius   <= RADIUS_W'(2);
      cfg_q.margin   <= MARGIN_W'(4);
      cfg_q.shift_lm <= '0;
      cfg_q.shift_cb <= '0;
      cfg_q.shift_cr <= '0;
    end else if (we_i) begin
      unique case (idx_i)
        REG_SEARCH_RADIUS: cfg_q.radius   <= data_i[RADIUS_W-1:0];
        REG_MARGIN:        cfg_q.margin   <= data_i[MARGIN_W-1:0];
        REG_SHIFT_LM:      cfg_q.shift_lm <= $signed(data_i[SHIFT_W-1:0]);
        REG_SHIFT_CB:      cfg_q.shift_cb <= $signed(data_i[SHIFT_W-1:0]);
        REG_SHIFT_CR:      cfg_q.shift_cr <= $signed(data_i[SHIFT_W-1:0]);
        default: ;
      endcase
    end
  end

  // clamp the window half size to what the scan counters can hold
  always_comb begin
    if (int'(cfg_q.radius) > MAX_RADIUS) begin
      radius_o = RadW'(MAX_RADIUS);
    end else begin
      radius_o = RadW'(cfg_q.radius);
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/cpss_scan.sv
module cpss_scan #(
  parameter int STORE_WIDTH  = 128,
  parameter int STORE_HEIGHT = 128,
  parameter int MAX_RADIUS   = 4,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  cpss_stream_if.sink                                    req_i,
  input  cpss_pkg::cfg_t                                 cfg_i,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]                radius_i,
  input  logic                                           busy_i,
  output logic                                           mem_we_o,
  output logic [$clog2(STORE_WIDTH*STORE_HEIGHT)-1:0]    mem_waddr_o,
  output logic [3*SAMPLE_BITS-1:0]                       mem_wdata_o,
  output logic                                           mem_re_o,
  output logic [$clog2(STORE_WIDTH*STORE_HEIGHT)-1:0]    mem_raddr_o,
  output cpss_pkg::scan_ctl_t                            ctl_o,
  output logic signed [cpss_pkg::TEST_W-1:0]             tst_o
);
  import cpss_pkg::*;

  localparam int Depth  = STORE_WIDTH * STORE_HEIGHT;
  localparam int AW     = $clog2(Depth);
  localparam int RadW   = $clog2(MAX_RADIUS + 1);
  localparam int SpanW  = $clog2(2 * MAX_RADIUS + 1);
  localparam int MaxDim = (STORE_WIDTH > STORE_HEIGHT) ? STORE_WIDTH : STORE_HEIGHT;
  localparam int CrdW   = ($clog2(MaxDim) + 1 > 9) ? $clog2(MaxDim) + 1 : 9;
  localparam int SumW   = SAMPLE_BITS + 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN
  } st_e;

  st_e                       st_q;
  logic                      rd_vld_q, rd_last_q;
  logic [SpanW-1:0]          dx_q, dy_q;
  logic [SpanW-1:0]          span_q;
  logic [COORD_W-1:0]        col_q, row_q;
  logic [SumW-1:0]           samp_sum_q;
  logic signed [TEST_W-1:0]  tst_q;
  logic [AW-1:0]             raddr_q;

  logic                      accept, in_store, last;
  logic [CrdW-1:0]           cx, cy, rx, x0, y0;
  logic                      oor;
  logic [AW-1:0]             start_addr;
  logic signed [TEST_W-1:0]  tst_d;

  assign req_i.ready = (st_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // load path: write straight into the store, drop positions beyond it
  assign in_store    = (int'(req_i.payload.column) < STORE_WIDTH) &&
                       (int'(req_i.payload.row) < STORE_HEIGHT);
  assign mem_we_o    = accept && (req_i.payload.operation == OP_LOAD) && in_store;
  assign mem_waddr_o = AW'(req_i.payload.row) * AW'(STORE_WIDTH) + AW'(req_i.payload.column);
  assign mem_wdata_o = {req_i.payload.cr_value[SAMPLE_BITS-1:0],
                        req_i.payload.cb_value[SAMPLE_BITS-1:0],
                        req_i.payload.lm_value[SAMPLE_BITS-1:0]};

  // window set-up
  assign rx  = CrdW'(radius_i);
  assign cx  = CrdW'(col_q) + CrdW'(cfg_i.margin);
  assign cy  = CrdW'(row_q) + CrdW'(cfg_i.margin);
  assign oor = (cx < rx) || (cy < rx) ||
               (cx + rx >= CrdW'(STORE_WIDTH)) || (cy + rx >= CrdW'(STORE_HEIGHT));
  assign x0  = cx - rx;
  assign y0  = cy - rx;
  assign start_addr = AW'(y0) * AW'(STORE_WIDTH) + AW'(x0);
  assign tst_d = TEST_W'(samp_sum_q) + TEST_W'(cfg_i.shift_lm) +
                 TEST_W'(cfg_i.shift_cb) + TEST_W'(cfg_i.shift_cr);

  assign last = (dx_q == span_q) && (dy_q == span_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      dx_q      <= '0;
      dy_q      <= '0;
    end else begin
      rd_vld_q  <= (st_q == ST_SCAN);
      rd_last_q <= (st_q == ST_SCAN) && last;
      unique case (st_q)
        ST_IDLE: begin
          if (accept && (req_i.payload.operation == OP_SEARCH)) begin
            st_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          dx_q <= '0;
          dy_q <= '0;
          st_q <= oor ? ST_DRAIN : ST_SCAN;
        end
        ST_SCAN: begin
          if (dx_q == span_q) begin
            dx_q <= '0;
            dy_q <= dy_q + SpanW'(1);
          end else begin
            dx_q <= dx_q + SpanW'(1);
          end
          if (last) begin
            st_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // hold until the last read has been judged and handed to the output
          if (!rd_vld_q && !busy_i) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q      <= req_i.payload.column;
      row_q      <= req_i.payload.row;
      samp_sum_q <= SumW'(req_i.payload.lm_value[SAMPLE_BITS-1:0]) +
                    SumW'(req_i.payload.cb_value[SAMPLE_BITS-1:0]) +
                    SumW'(req_i.payload.cr_value[SAMPLE_BITS-1:0]);
    end
    if (st_q == ST_SETUP) begin
      tst_q   <= tst_d;
      raddr_q <= start_addr;
      span_q  <= SpanW'({radius_i, 1'b0});
    end else if (st_q == ST_SCAN) begin
      // step right, or wrap to the first column of the next window row
      if (dx_q == span_q) begin
        raddr_q <= raddr_q + AW'(STORE_WIDTH) - AW'(span_q);
      end else begin
        raddr_q <= raddr_q + AW'(1);
      end
    end
  end

  assign mem_re_o      = (st_q == ST_SCAN);
  assign mem_raddr_o   = raddr_q;
  assign ctl_o.start   = (st_q == ST_SETUP);
  assign ctl_o.oor     = oor;
  assign ctl_o.rd_vld  = rd_vld_q;
  assign ctl_o.rd_last = rd_last_q;
  assign tst_o         = tst_q;

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && (st_q == ST_SCAN)))
    else $error("store written during a window scan");

  a_addr_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN) |-> ({1'b0, raddr_q} < (AW+1)'(Depth)))
    else $error("scan address beyond the store");

  a_setup_leads_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.start |=> ((st_q == ST_SCAN) || (st_q == ST_DRAIN)))
    else $error("set-up not followed by scan or drain");

endmodule

// File: rtl/core/cpss_best.sv
module cpss_best #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cpss_pkg::scan_ctl_t                 ctl_i,
  input  logic signed [cpss_pkg::TEST_W-1:0]  tst_i,
  input  logic [3*SAMPLE_BITS-1:0]            rdata_i,
  output logic                                busy_o,
  cpss_stream_if.source                       rsp_o
);
  import cpss_pkg::*;

  localparam int SumW = SAMPLE_BITS + 2;
  localparam int PixW = 3 * SAMPLE_BITS;

  logic                      a_vld_q, a_last_q, first_q, pend_q, oor_q, rsp_vld_q;
  logic signed [TEST_W-1:0]  diff_q;
  logic [PixW-1:0]           pix_q, best_pix_q;
  logic [DIST_W-1:0]         best_d_q;
  rsp_t                      rsp_q;

  logic [SumW-1:0]           ref_sum;
  logic signed [TEST_W-1:0]  diff_d, mag;
  logic [DIST_W-1:0]         absd;
  logic                      better, move;

  assign ref_sum = SumW'(rdata_i[SAMPLE_BITS-1:0]) +
                   SumW'(rdata_i[2*SAMPLE_BITS-1:SAMPLE_BITS]) +
                   SumW'(rdata_i[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);
  assign diff_d  = tst_i - TEST_W'(ref_sum);

  assign mag    = diff_q[TEST_W-1] ? -diff_q : diff_q;
  assign absd   = mag[DIST_W-1:0];
  // strict less keeps the earliest candidate on a tie
  assign better = first_q || (absd < best_d_q);
  assign move   = pend_q && (!rsp_vld_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      a_last_q  <= 1'b0;
      first_q   <= 1'b0;
      oor_q     <= 1'b0;
      pend_q    <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      a_vld_q  <= ctl_i.rd_vld;
      a_last_q <= ctl_i.rd_vld && ctl_i.rd_last;
      if (ctl_i.start) begin
        first_q <= !ctl_i.oor;
        oor_q   <= ctl_i.oor;
      end else if (a_vld_q) begin
        first_q <= 1'b0;
      end
      if ((ctl_i.start && ctl_i.oor) || (a_vld_q && a_last_q)) begin
        pend_q <= 1'b1;
      end else if (move) begin
        pend_q <= 1'b0;
      end
      if (move) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_vld) begin
      diff_q <= diff_d;
      pix_q  <= rdata_i;
    end
    if (ctl_i.start && ctl_i.oor) begin
      best_pix_q <= '0;
      best_d_q   <= '0;
    end else if (a_vld_q && better) begin
      best_pix_q <= pix_q;
      best_d_q   <= absd;
    end
    if (move) begin
      rsp_q.best_lm      <= SAMPLE_W'(best_pix_q[SAMPLE_BITS-1:0]);
      rsp_q.best_cb      <= SAMPLE_W'(best_pix_q[2*SAMPLE_BITS-1:SAMPLE_BITS]);
      rsp_q.best_cr      <= SAMPLE_W'(best_pix_q[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);
      rsp_q.min_distance <= best_d_q;
      rsp_q.out_of_range <= oor_q;
    end
  end

  assign busy_o        = a_vld_q || pend_q;
  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

  a_pend_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !a_vld_q)
    else $error("candidate judged while a result is pending");

endmodule

// File: rtl/core/corresponding_pixel_shift_search_unit.sv
// channel   dir   payload                                         handshake
// req_i     in    operation, column, row, lm/cb/cr_value          valid/ready
// rsp_o     out   best_lm/cb/cr, min_distance, out_of_range       valid/ready
// cfg       in    cfg_idx_i, cfg_data_i                           cfg_we_i, no stall
//
// A load request writes the store directly.
// A search request makes one store read per window position, (2r+1)^2 in
// all with r the clamped radius, on the single read port; a set-up state
// comes before the reads, and after them a drain through the distance stages
// returns the sequencer to idle, where the next request is taken.
// A window leaving the store goes from set-up straight to the drain state,
// skipping the reads, and then back to idle.
// The result sits in an output register, so the next request is taken while
// it waits; a stalled output only holds a search at its final hand-over.
// Reset clears control and sets configuration to its defaults; the store has
// no clearing pass and reads as undefined until loaded.
module corresponding_pixel_shift_search_unit #(
  parameter int STORE_WIDTH  = 128,
  parameter int STORE_HEIGHT = 128,
  parameter int MAX_RADIUS   = 4,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cpss_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cpss_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  cpss_stream_if.sink                      req_i,
  cpss_stream_if.source                    rsp_o
);
  import cpss_pkg::*;

  localparam int Depth = STORE_WIDTH * STORE_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int RadW  = $clog2(MAX_RADIUS + 1);
  localparam int PixW  = 3 * SAMPLE_BITS;

  cfg_t                     cfg;
  logic [RadW-1:0]          radius;
  scan_ctl_t                ctl;
  logic signed [TEST_W-1:0] tst;
  logic                     busy;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [PixW-1:0]          mem_wdata, mem_rdata;

  // configuration registers; the window half size leaves clamped
  cpss_cfg #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (cfg_we_i),
    .idx_i    (cfg_idx_i),
    .data_i   (cfg_data_i),
    .cfg_o    (cfg),
    .radius_o (radius)
  );

  // request intake, store writes and the raster walk over the window
  cpss_scan #(
    .STORE_WIDTH  (STORE_WIDTH),
    .STORE_HEIGHT (STORE_HEIGHT),
    .MAX_RADIUS   (MAX_RADIUS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_i       (cfg),
    .radius_i    (radius),
    .busy_i      (busy),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .ctl_o       (ctl),
    .tst_o       (tst)
  );

  // reference store: one row-major entry of three samples per position
  cpss_ram #(
    .Width (PixW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // two-stage distance and running minimum, then the output register
  cpss_best #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_best (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .tst_i   (tst),
    .rdata_i (mem_rdata),
    .busy_o  (busy),
    .rsp_o   (rsp_o)
  );

endmodule
